[design/fmfrt_pkg.sv]
// Package for the first-match flow rule table: payload types, codes, sizes.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package fmfrt_pkg;

  localparam int RuleSlots = 64;
  localparam int SlotW     = $clog2(RuleSlots);
  localparam int CountW    = $clog2(RuleSlots + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_MATCH  = 2'd2;

  localparam logic [1:0] KIND_ANY  = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_IPV6 = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic [1:0] REG_DEFAULT_ACTION = 2'd0;
  localparam logic [1:0] REG_DEFAULT_KEY    = 2'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] exe_id;
    logic        exe_wild;
    logic [1:0]  addr_kind;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        port_wild;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [1:0]  rule_action;
    logic [31:0] rule_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [5:0]  hit_index;
    logic [1:0]  result_action;
    logic [31:0] result_key;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clear;     // empty the table
    logic write;     // append captured rule
    logic scan_rst;  // restart scan pointer
    logic scan_step; // advance scan pointer
    logic emit;      // build result into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       bad_addr;
    logic       full;
    logic       scan_end;  // pointer reached rule count
    logic       match;     // registered compare of last read slot
    logic       match_vld;
  } dp_stat_t;

endpackage

[design/fmfrt_datapath.sv]
// Datapath of the rule table: rule memory, scan pointer, compare, result register.
// Depends on fmfrt_pkg.
`timescale 1ns / 1ps
module fmfrt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  fmfrt_pkg::in_item_t in_item,
  input  fmfrt_pkg::dp_cmd_t  cmd,
  output fmfrt_pkg::dp_stat_t stat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output fmfrt_pkg::out_item_t result
);
  import fmfrt_pkg::*;

  typedef struct packed {
    logic [63:0] exe;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  kind;
    logic        pwild;
    logic        ewild;
    logic [15:0] plo;
    logic [15:0] phi;
    logic [1:0]  act;
    logic [31:0] key;
  } rule_t;

  rule_t            mem [RuleSlots];
  rule_t            rd;
  in_item_t         cur;
  logic [CountW-1:0] rule_count;
  logic [CountW-1:0] ptr;
  logic [SlotW-1:0]  rd_idx;
  logic              rd_vld;
  logic              match;
  logic              match_vld;
  logic [SlotW-1:0]  match_idx;
  logic [1:0]        miss_action;
  logic [31:0]       miss_key;
  logic              cmp;
  out_item_t         res_next;

  // Hold the config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_action <= '0;
      miss_key    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEFAULT_ACTION) miss_action <= cfg_data[1:0];
      if (cfg_index == REG_DEFAULT_KEY)    miss_key    <= cfg_data;
    end
  end

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_item;
  end

  // Rule count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      rule_count <= '0;
    end else if (cmd.write) begin
      rule_count <= rule_count + 1'b1;
    end
  end

  // Append port and registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[rule_count[SlotW-1:0]] <= '{exe: cur.exe_id, hi: cur.addr_upper,
        lo: cur.addr_lower, kind: cur.addr_kind, pwild: cur.port_wild,
        ewild: cur.exe_wild, plo: cur.port_low, phi: cur.port_high,
        act: cur.rule_action, key: cur.rule_key};
    end
    rd <= mem[ptr[SlotW-1:0]];
  end

  // Scan pointer; each step issues a registered read of the slot it pointed at
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      ptr    <= ptr + 1'b1;
      rd_vld <= 1'b1;
      rd_idx <= ptr[SlotW-1:0];
    end else begin
      rd_vld <= 1'b0;
    end
  end

  // Compare the slot that was read
  always_comb begin
    cmp = (rd.ewild || rd.exe == cur.exe_id) &&
          (rd.pwild || (cur.port_low >= rd.plo && cur.port_low <= rd.phi));
    if (rd.kind != KIND_ANY) begin
      if (cur.addr_kind != rd.kind) cmp = 1'b0;
      else if (rd.kind == KIND_IPV4) begin
        if (rd.lo[31:0] != cur.addr_lower[31:0]) cmp = 1'b0;
      end else if (rd.lo != cur.addr_lower || rd.hi != cur.addr_upper) cmp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_rst) begin
      match_vld <= 1'b0;
      match     <= 1'b0;
    end else begin
      match_vld <= rd_vld;
      match     <= rd_vld && cmp;
      if (rd_vld && cmp) match_idx <= rd_idx;
    end
  end

  // Hold the action and key of each slot read, alongside its registered compare
  logic [1:0]  hit_act;
  logic [31:0] hit_key;
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      hit_act <= rd.act;
      hit_key <= rd.key;
    end
  end

  // Build the result
  always_comb begin
    res_next        = '0;
    res_next.status = ST_OK;
    unique case (cur.command)
      CMD_APPEND: begin
        if (cur.addr_kind == KIND_BAD) res_next.status = ST_BADADDR;
        else if (rule_count == CountW'(RuleSlots)) res_next.status = ST_FULL;
      end
      CMD_MATCH: begin
        if (match) begin
          res_next.hit           = 1'b1;
          res_next.hit_index     = 6'(match_idx);
          res_next.result_action = hit_act;
          res_next.result_key    = hit_key;
        end else begin
          res_next.result_action = miss_action;
          res_next.result_key    = miss_key;
        end
      end
      default: ;
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.emit) result <= res_next;
  end

  assign stat.command   = cur.command;
  assign stat.bad_addr  = cur.addr_kind == KIND_BAD;
  assign stat.full      = rule_count == CountW'(RuleSlots);
  assign stat.scan_end  = ptr == rule_count;
  assign stat.match     = match;
  assign stat.match_vld = match_vld;

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (rule_count <= CountW'(RuleSlots)) else $error("rule count overflow");
    end
  end
  a_nowrite_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> rule_count < CountW'(RuleSlots)) else $error("append to full table");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> ptr < rule_count) else $error("scan beyond rule count");
  a_match_vld: assert property (@(posedge clk) disable iff (rst)
    match |-> match_vld) else $error("match without read");

endmodule

[design/fmfrt_ctrl.sv]
// Controller of the rule table: sequences load, append, scan and result delivery.
// Depends on fmfrt_pkg.
`timescale 1ns / 1ps
module fmfrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fmfrt_pkg::dp_stat_t stat,
  output fmfrt_pkg::dp_cmd_t  cmd
);
  import fmfrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_rst = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.command)
          CMD_CLEAR: begin
            cmd.emit  = 1'b1;
            cmd.clear = 1'b1;
            state_next = S_OUT;
          end
          CMD_APPEND: begin
            cmd.emit  = 1'b1;
            cmd.write = !stat.bad_addr && !stat.full;
            state_next = S_OUT;
          end
          CMD_MATCH: begin
            state_next = S_SCAN;
          end
          default: begin
            cmd.emit   = 1'b1;
            state_next = S_OUT;
          end
        endcase
      end
      S_SCAN: begin
        // Stop once a match is seen or every stored rule has been issued
        if (stat.match) begin
          cmd.emit   = 1'b1;
          state_next = S_OUT;
        end else if (stat.scan_end) begin
          state_next = S_DRAIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DRAIN: begin
        // Wait for reads in flight to be compared
        if (stat.match || !stat.match_vld) begin
          cmd.emit   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept during output");
  a_emit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("emit without output");

endmodule

[design/first_match_flow_rule_table.sv]
// First-match flow rule table, top level: controller plus datapath.
// Depends on fmfrt_pkg, fmfrt_ctrl, fmfrt_datapath.
`timescale 1ns / 1ps
// One item at a time: the input stalls from acceptance until the result is taken.
// A clear, append or unused command passes through the execute state straight to
// the output state. A match reads one stored rule per cycle from the rule memory
// through a read stage and a compare stage, stopping at the first hit or after the
// last stored rule. The single read port of the rule memory sets the rate. Config
// writes are taken at any time but must be made only while idle.
module first_match_flow_rule_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fmfrt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fmfrt_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import fmfrt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fmfrt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  fmfrt_datapath u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .result(out_data)
  );

endmodule

[tb/tb_first_match_flow_rule_table.sv]
// Testbench for the first-match flow rule table: directed and random commands
// checked against an in-bench rule table predictor. Depends on fmfrt_pkg and the RTL.
`timescale 1ns / 1ps
module tb_first_match_flow_rule_table;
  import fmfrt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd2;
  localparam int CycleLimit = 900000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  first_match_flow_rule_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: a copy of the rule table and the miss registers
  logic [1:0]  miss_action;
  logic [31:0] miss_key;
  int          stored_rules;
  in_item_t    rule_table [RuleSlots];
  out_item_t   pending_results [$];
  int          fail_count = 0;
  int          cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("first_match_flow_rule_table test failed");
      $finish;
    end
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic bit rule_hits(in_item_t r, in_item_t f);
    if (!r.exe_wild && r.exe_id != f.exe_id) return 0;
    if (!r.port_wild && (f.port_low < r.port_low || f.port_low > r.port_high)) return 0;
    if (r.addr_kind != KIND_ANY) begin
      if (f.addr_kind != r.addr_kind) return 0;
      if (r.addr_kind == KIND_IPV4) begin
        if (r.addr_lower[31:0] != f.addr_lower[31:0]) return 0;
      end else if (r.addr_lower != f.addr_lower || r.addr_upper != f.addr_upper) begin
        return 0;
      end
    end
    return 1;
  endfunction

  // Apply one command to the table copy and queue its result
  function automatic void predict_command(in_item_t it);
    out_item_t res;
    res = '0;
    case (it.command)
      CMD_CLEAR: stored_rules = 0;
      CMD_APPEND: begin
        if (it.addr_kind == KIND_BAD) res.status = ST_BADADDR;
        else if (stored_rules >= RuleSlots) res.status = ST_FULL;
        else begin
          rule_table[stored_rules] = it;
          stored_rules++;
        end
      end
      CMD_MATCH: begin
        res.result_action = miss_action;
        res.result_key = miss_key;
        for (int i = 0; i < stored_rules; i++) begin
          if (rule_hits(rule_table[i], it)) begin
            res.hit = 1'b1;
            res.hit_index = i[5:0];
            res.result_action = rule_table[i].rule_action;
            res.result_key = rule_table[i].rule_key;
            break;
          end
        end
      end
      default: ;
    endcase
    pending_results = {pending_results, res};
  endfunction

  // Drive one item and hold it until accepted; valid stays high with no gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = short_or_long_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(it);
  endtask

  // Receiver stall pattern
  initial begin
    int stall_len;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 3) begin
        stall_len = short_or_long_gap();
        if (stall_len != 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (want.status != out_data.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, out_data.status);
        if (want.hit != out_data.hit)
          $display("%0t: hit exp %0d got %0d", $time, want.hit, out_data.hit);
        if (want.hit_index != out_data.hit_index)
          $display("%0t: hit_index exp %0d got %0d", $time, want.hit_index,
                   out_data.hit_index);
        if (want.result_action != out_data.result_action)
          $display("%0t: action exp %0d got %0d", $time, want.result_action,
                   out_data.result_action);
        if (want.result_key != out_data.result_key)
          $display("%0t: key exp %h got %h", $time, want.result_key, out_data.result_key);
        if (want != out_data) fail_count++;
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEFAULT_ACTION) miss_action = val[1:0];
    else if (idx == REG_DEFAULT_KEY) miss_key = val;
    @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    logic [287:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // Small value pools so rules and flows collide often
  function automatic in_item_t pooled_item(logic [1:0] cmd);
    in_item_t it;
    it = random_item();
    it.command = cmd;
    it.exe_id = (it.exe_id[63] && cmd == CMD_MATCH) ? it.exe_id : 64'(it.exe_id[1:0]);
    it.addr_upper = 64'(it.addr_upper[0]) |
                    (it.addr_upper[1] ? 64'hFFFF_0000_0000_0000 : 64'h0);
    it.addr_lower = {it.addr_lower[63:62], 60'h0, it.addr_lower[1:0]};
    it.port_low = $urandom_range(0, 3) == 0 ? it.port_low : 16'($urandom_range(0, 40));
    it.port_high = $urandom_range(0, 3) == 0 ? it.port_high : 16'($urandom_range(0, 60));
    if (cmd == CMD_APPEND && $urandom_range(0, 15) == 0) it.addr_kind = KIND_BAD;
    else if (cmd == CMD_APPEND && it.addr_kind == KIND_BAD) it.addr_kind = KIND_ANY;
    it.exe_wild = $urandom_range(0, 3) == 0;
    it.port_wild = $urandom_range(0, 3) == 0;
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    send_item(pooled_item(CMD_MATCH));           // match on an empty table
    it = '0; it.command = CMD_APPEND; it.addr_kind = KIND_BAD;
    send_item(it);                                // invalid address skipped
    it = '1; it.command = CMD_APPEND; it.addr_kind = KIND_IPV6; it.port_low = 16'hFFFF;
    send_item(it);
    it.command = CMD_MATCH; send_item(it);        // all-ones IPv6 hit, action 3
    it.addr_kind = KIND_BAD; send_item(it);       // bad flow kind misses IPv6 rule
    it = '0; it.command = CMD_APPEND; it.addr_kind = KIND_IPV4;
    it.addr_upper = 64'h1234; it.addr_lower = 64'hDEAD_0000_0A00_0001;
    it.port_low = 16'd10; it.port_high = 16'd20; it.rule_action = 2'd2; it.rule_key = '1;
    send_item(it);
    it.command = CMD_MATCH; it.addr_lower = 64'h0000_0000_0A00_0001; it.port_low = 16'd20;
    send_item(it);                                // IPv4 compares low 32 bits only
    it.port_low = 16'd21; send_item(it);          // above range
    it = '0; it.command = CMD_APPEND; it.port_low = 16'd9; it.port_high = 16'd3;
    send_item(it);                                // empty range
    it.command = CMD_MATCH; it.port_low = 16'd5; send_item(it);
    it = '0; it.command = CMD_UNUSED; send_item(it);
    it = '0; it.command = CMD_CLEAR; send_item(it);
    // Fill past capacity
    for (int i = 0; i < RuleSlots + 2; i++) begin
      it = pooled_item(CMD_APPEND);
      it.addr_kind = KIND_ANY;
      send_item(it);
    end
    send_item(pooled_item(CMD_MATCH));
    it = '0; it.command = CMD_MATCH; it.exe_id = '1; it.port_low = 16'hFFFF;
    send_item(it);
    wait_drained();
  endtask

  task automatic test_random(int count, int table_cap);
    int filled;
    filled = 0;
    for (int n = 0; n < count; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3 || filled >= table_cap) begin
        send_item(pooled_item(CMD_CLEAR));
        filled = 0;
      end else if (pick < 40) begin
        send_item(pooled_item(CMD_APPEND));
        filled++;
      end else if (pick < 97) send_item(pooled_item(CMD_MATCH));
      else send_item(random_item());
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    miss_action = '0;
    miss_key = '0;
    stored_rules = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(REG_DEFAULT_ACTION, 32'd3);
    write_reg(REG_DEFAULT_KEY, 32'hFFFF_FFFF);
    test_random(250, 12);
    write_reg(REG_DEFAULT_ACTION, 32'd1);
    write_reg(REG_DEFAULT_KEY, $urandom);
    write_reg(REG_UNUSED, $urandom);
    test_random(250, 70);
    write_reg(REG_DEFAULT_ACTION, 32'd0);
    write_reg(REG_DEFAULT_KEY, 32'd0);
    test_random(200, 20);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("first_match_flow_rule_table test passed");
    end else begin
      $display("first_match_flow_rule_table test failed");
    end
    $finish;
  end

endmodule
